>>> src/os_fingerprint_scorer_defines.svh
// Assertion macros used by the checker of the fingerprint scorer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef OS_FINGERPRINT_SCORER_DEFINES_SVH
`define OS_FINGERPRINT_SCORER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("os_fingerprint_scorer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("os_fingerprint_scorer: next-cycle check failed");

`endif

>>> src/ofs_pkg.sv
// Types, constants and helper functions of the fingerprint scorer.
// No dependencies; imported by ofs_cell and os_fingerprint_scorer.
package ofs_pkg;

    localparam int TTL_W   = 8;
    localparam int WIN_W   = 32;
    localparam int MSS_W   = 16;
    localparam int FLAG_W  = 4;
    localparam int CONF_W  = 7;
    localparam int SCORE_W = 7;
    localparam int ENTRY_W = 4;
    localparam int COUNT_W = 5;
    // Raw scores are multiples of five and are kept in units of five.
    localparam int UNIT_W  = 5;
    localparam int PROD_W  = 12;

    localparam logic [UNIT_W-1:0] TTL_FULL_UNITS = 5'd8;
    localparam logic [UNIT_W-1:0] WIN_FULL_UNITS = 5'd6;
    localparam logic [UNIT_W-1:0] NEAR_UNITS     = 5'd2;
    localparam logic [UNIT_W-1:0] MSS_UNITS      = 5'd3;

    localparam logic [CONF_W-1:0]  CONF_MAX         = 7'd100;
    localparam logic [SCORE_W-1:0] MIN_SCORE_RESET  = 7'd25;
    localparam logic [TTL_W-1:0]   TTL_MARGIN_RESET = 8'd10;
    localparam logic [WIN_W-1:0]   WIN_MARGIN_RESET = 32'd5000;

    typedef enum logic {
        OP_LOAD,
        OP_CLASSIFY
    } op_t;

    typedef enum logic [1:0] {
        REG_ACTIVE_ENTRIES,
        REG_MIN_SCORE,
        REG_TTL_MARGIN,
        REG_WINDOW_MARGIN
    } cfg_reg_t;

    typedef struct packed {
        logic [TTL_W-1:0]  ttl;
        logic [WIN_W-1:0]  window;
        logic [MSS_W-1:0]  mss;
        logic [FLAG_W-1:0] flags;
    } obs_t;

    typedef struct packed {
        logic [TTL_W-1:0]  ttl_lo;
        logic [TTL_W-1:0]  ttl_hi;
        logic [TTL_W-1:0]  ttl_mid;
        logic [WIN_W-1:0]  win_lo;
        logic [WIN_W-1:0]  win_hi;
        logic [WIN_W-1:0]  win_mid;
        logic [MSS_W-1:0]  mss;
        logic [FLAG_W-1:0] flags;
        logic [CONF_W-1:0] conf;
    } sig_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [SCORE_W-1:0] score;
    } best_t;

    // Units of five times confidence, divided by twenty: drop two bits, then
    // divide by five through a reciprocal that is exact for ten-bit values.
    function automatic logic [SCORE_W-1:0] div_by_20(input logic [PROD_W-1:0] prod);
        logic [PROD_W-3:0] quarter;
        logic [17:0]       scaled;
        quarter = prod[PROD_W-1:2];
        scaled  = 18'(quarter) * 18'd205;
        return scaled[16:10];
    endfunction

endpackage

>>> src/ofs_cell.sv
// One cell of the scoring chain: holds one signature entry and scores it.
// Depends on ofs_pkg; instantiated once per table entry by os_fingerprint_scorer.
module ofs_cell
    import ofs_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  logic [ENTRY_W-1:0]   load_index,
    input  sig_t                 load_sig,
    input  logic [COUNT_W-1:0]   active_entries,
    input  logic [TTL_W-1:0]     ttl_margin,
    input  logic [WIN_W-1:0]     window_margin,
    input  logic                 obs_valid_in,
    input  obs_t                 obs_in,
    output logic                 obs_valid_out,
    output obs_t                 obs_out,
    input  best_t                best_in,
    input  logic [IDX_W-1:0]     best_idx_in,
    output best_t                best_out,
    output logic [IDX_W-1:0]     best_idx_out
);

    sig_t                sig_reg;
    logic                obs_valid_reg;
    obs_t                obs_reg;
    logic [UNIT_W-1:0]   units_reg;
    logic [UNIT_W-1:0]   units_next;
    logic [PROD_W-1:0]   prod_reg;
    best_t               best_reg;
    best_t               best_next;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [IDX_W-1:0]    best_idx_next;

    logic                ttl_in_range;
    logic                ttl_near;
    logic [TTL_W-1:0]    ttl_dist;
    logic                win_in_range;
    logic                win_near;
    logic [WIN_W-1:0]    win_dist;
    logic [UNIT_W-1:0]   ttl_units;
    logic [UNIT_W-1:0]   win_units;
    logic [UNIT_W-1:0]   mss_units;
    logic [UNIT_W-1:0]   flag_units;
    logic [FLAG_W-1:0]   flags_same;
    logic [SCORE_W-1:0]  weighted;
    logic                active;
    logic                take;

    always_ff @(posedge clk)
    begin
        if (load_en && (32'(load_index) == INDEX))
        begin
            sig_reg <= load_sig;
        end
    end

    // First stage: raw score of the observation arriving from the left.
    assign ttl_in_range = (obs_in.ttl >= sig_reg.ttl_lo) && (obs_in.ttl <= sig_reg.ttl_hi);
    assign ttl_dist     = (obs_in.ttl >= sig_reg.ttl_mid) ? (obs_in.ttl - sig_reg.ttl_mid)
                                                          : (sig_reg.ttl_mid - obs_in.ttl);
    assign ttl_near     = (ttl_dist <= ttl_margin);

    assign win_in_range = (obs_in.window >= sig_reg.win_lo) && (obs_in.window <= sig_reg.win_hi);
    assign win_dist     = (obs_in.window >= sig_reg.win_mid) ? (obs_in.window - sig_reg.win_mid)
                                                             : (sig_reg.win_mid - obs_in.window);
    assign win_near     = (win_dist <= window_margin);

    assign ttl_units  = ttl_in_range ? TTL_FULL_UNITS : (ttl_near ? NEAR_UNITS : '0);
    assign win_units  = win_in_range ? WIN_FULL_UNITS : (win_near ? NEAR_UNITS : '0);
    assign mss_units  = ((sig_reg.mss != '0) && (obs_in.mss == sig_reg.mss)) ? MSS_UNITS : '0;
    assign flags_same = ~(obs_in.flags ^ sig_reg.flags);
    assign flag_units = UNIT_W'($countones(flags_same));
    assign units_next = ttl_units + win_units + mss_units + flag_units;

    always_ff @(posedge clk)
    begin
        units_reg <= units_next;
        prod_reg  <= PROD_W'(units_reg) * PROD_W'(sig_reg.conf);
        obs_reg   <= obs_in;
    end

    // Third stage: the running best from the left cell meets this entry's score.
    assign weighted = div_by_20(prod_reg);
    assign active   = (32'(active_entries) > INDEX);
    assign take     = active && (weighted > best_in.score);

    always_comb
    begin
        best_next.valid = best_in.valid;
        best_next.found = best_in.found || take;
        best_next.score = take ? weighted : best_in.score;
        best_idx_next   = take ? IDX_W'(INDEX) : best_idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_valid_reg <= 1'b0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
        end
        else
        begin
            obs_valid_reg <= obs_valid_in;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
        end
    end

    assign obs_valid_out = obs_valid_reg;
    assign obs_out       = obs_reg;
    assign best_out      = best_reg;
    assign best_idx_out  = best_idx_reg;

endmodule

>>> src/os_fingerprint_scorer.sv
// Passive TCP fingerprint scorer. A load word writes one signature entry. A classify
// word enters a chain of MAX_SIGNATURES cells, one per entry: the observation moves
// one cell to the right each cycle, and each cell scores its entry in three register
// stages (raw score, confidence product, divide and compare), so the running best
// trails the observation, held back by the start_d1 and start_d2 registers. A classify
// word keeps the block busy until its result has moved to an output register, where
// it sits while the next word is taken. Only one classify word is in the chain at a
// time.
// Depends on ofs_pkg and ofs_cell.
module os_fingerprint_scorer
    import ofs_pkg::*;
#(
    parameter int MAX_SIGNATURES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [WIN_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [ENTRY_W-1:0]  entry_index,
    input  logic [TTL_W-1:0]    ttl_value,
    input  logic [TTL_W-1:0]    ttl_high,
    input  logic [WIN_W-1:0]    window_value,
    input  logic [WIN_W-1:0]    window_high,
    input  logic [MSS_W-1:0]    mss_value,
    input  logic [FLAG_W-1:0]   option_flags,
    input  logic [CONF_W-1:0]   confidence,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                matched,
    output logic [ENTRY_W-1:0]  match_index,
    output logic [SCORE_W-1:0]  top_score
);

    localparam int M     = MAX_SIGNATURES;
    localparam int IDX_W = (M > 1) ? $clog2(M) : 1;

    logic [COUNT_W-1:0]  active_entries_reg;
    logic [SCORE_W-1:0]  min_score_reg;
    logic [TTL_W-1:0]    ttl_margin_reg;
    logic [WIN_W-1:0]    window_margin_reg;

    logic                busy_reg;
    logic                start_d1_reg;
    logic                start_d2_reg;
    logic                accept;
    logic                load_en;
    logic                start;

    logic [TTL_W:0]      ttl_sum;
    logic [WIN_W:0]      win_sum;
    sig_t                load_sig;
    obs_t                obs_start;
    best_t               best_start;

    logic                obs_valid_chain [0:M-1];
    obs_t                obs_chain       [0:M-1];
    best_t               best_chain      [0:M];
    logic [IDX_W-1:0]    idx_chain       [0:M];

    logic                chain_done;
    logic                final_match;
    logic                res_valid_reg;
    logic                res_matched_reg;
    logic [ENTRY_W-1:0]  res_index_reg;
    logic [SCORE_W-1:0]  res_score_reg;
    logic                out_free;
    logic                move_out;
    logic                out_valid_reg;
    logic                out_matched_reg;
    logic [ENTRY_W-1:0]  out_index_reg;
    logic [SCORE_W-1:0]  out_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_entries_reg <= '0;
            min_score_reg      <= MIN_SCORE_RESET;
            ttl_margin_reg     <= TTL_MARGIN_RESET;
            window_margin_reg  <= WIN_MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ACTIVE_ENTRIES: active_entries_reg <= cfg_wdata[COUNT_W-1:0];
                REG_MIN_SCORE:      min_score_reg      <= cfg_wdata[SCORE_W-1:0];
                REG_TTL_MARGIN:     ttl_margin_reg     <= cfg_wdata[TTL_W-1:0];
                REG_WINDOW_MARGIN:  window_margin_reg  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign load_en  = accept && (operation == OP_LOAD);
    assign start    = accept && (operation == OP_CLASSIFY);

    // Midpoints and the confidence clamp are settled once at load time.
    assign ttl_sum = {1'b0, ttl_value} + {1'b0, ttl_high};
    assign win_sum = {1'b0, window_value} + {1'b0, window_high};

    always_comb
    begin
        load_sig.ttl_lo  = ttl_value;
        load_sig.ttl_hi  = ttl_high;
        load_sig.ttl_mid = ttl_sum[TTL_W:1];
        load_sig.win_lo  = window_value;
        load_sig.win_hi  = window_high;
        load_sig.win_mid = win_sum[WIN_W:1];
        load_sig.mss     = mss_value;
        load_sig.flags   = option_flags;
        load_sig.conf    = (confidence > CONF_MAX) ? CONF_MAX : confidence;

        obs_start.ttl    = ttl_value;
        obs_start.window = window_value;
        obs_start.mss    = mss_value;
        obs_start.flags  = option_flags;

        best_start.valid = start_d2_reg;
        best_start.found = 1'b0;
        best_start.score = '0;
    end

    assign obs_valid_chain[0] = start;
    assign obs_chain[0]       = obs_start;
    assign best_chain[0]      = best_start;
    assign idx_chain[0]       = '0;

    genvar gi;
    generate
        for (gi = 0; gi < M; gi++)
        begin : g_cell
            if (gi < M - 1)
            begin : g_mid
                ofs_cell #(
                    .INDEX (gi),
                    .IDX_W (IDX_W)
                ) u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .load_en        (load_en),
                    .load_index     (entry_index),
                    .load_sig       (load_sig),
                    .active_entries (active_entries_reg),
                    .ttl_margin     (ttl_margin_reg),
                    .window_margin  (window_margin_reg),
                    .obs_valid_in   (obs_valid_chain[gi]),
                    .obs_in         (obs_chain[gi]),
                    .obs_valid_out  (obs_valid_chain[gi+1]),
                    .obs_out        (obs_chain[gi+1]),
                    .best_in        (best_chain[gi]),
                    .best_idx_in    (idx_chain[gi]),
                    .best_out       (best_chain[gi+1]),
                    .best_idx_out   (idx_chain[gi+1])
                );
            end
            else
            begin : g_last
                ofs_cell #(
                    .INDEX (gi),
                    .IDX_W (IDX_W)
                ) u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .load_en        (load_en),
                    .load_index     (entry_index),
                    .load_sig       (load_sig),
                    .active_entries (active_entries_reg),
                    .ttl_margin     (ttl_margin_reg),
                    .window_margin  (window_margin_reg),
                    .obs_valid_in   (obs_valid_chain[gi]),
                    .obs_in         (obs_chain[gi]),
                    .obs_valid_out  (),
                    .obs_out        (),
                    .best_in        (best_chain[gi]),
                    .best_idx_in    (idx_chain[gi]),
                    .best_out       (best_chain[gi+1]),
                    .best_idx_out   (idx_chain[gi+1])
                );
            end
        end
    endgenerate

    assign chain_done  = best_chain[M].valid;
    assign final_match = best_chain[M].found && (best_chain[M].score >= min_score_reg);
    assign out_free    = !out_valid_reg || out_ready;
    assign move_out    = res_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_d1_reg  <= 1'b0;
            start_d2_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_d1_reg <= start;
            start_d2_reg <= start_d1_reg;
            // The block stays busy until the result has moved to the output register.
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (move_out)
            begin
                busy_reg <= 1'b0;
            end
            if (chain_done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (move_out)
            begin
                res_valid_reg <= 1'b0;
            end
            if (move_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_done)
        begin
            res_matched_reg <= final_match;
            res_index_reg   <= final_match ? ENTRY_W'(idx_chain[M]) : '0;
            res_score_reg   <= best_chain[M].score;
        end
        if (move_out)
        begin
            out_matched_reg <= res_matched_reg;
            out_index_reg   <= res_index_reg;
            out_score_reg   <= res_score_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign matched     = out_matched_reg;
    assign match_index = out_index_reg;
    assign top_score   = out_score_reg;

endmodule

>>> src/ofs_checker.sv
// Port-level checker for os_fingerprint_scorer, attached by the bind below.
// Depends on os_fingerprint_scorer_defines.svh for the assertion macros.
`include "os_fingerprint_scorer_defines.svh"

module ofs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        operation,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        matched,
    input  logic [3:0]  match_index,
    input  logic [6:0]  top_score
);

    logic [11:0] out_word;

    assign out_word = {matched, match_index, top_score};

    // A stalled result word keeps its contents.
    `OFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

    // Without a match the reported index is zero.
    `OFS_ASSERT_NOW(a_nomatch_index, clk, rst_n, out_valid && !matched, match_index == 4'd0)

    // A match always carries a positive score.
    `OFS_ASSERT_NOW(a_match_positive, clk, rst_n, out_valid && matched, top_score != 7'd0)

    // The weighted score can never exceed the full raw score.
    `OFS_ASSERT_NOW(a_score_range, clk, rst_n, out_valid, top_score <= 7'd105)

    // Once a classify word is taken, the chain is closed to new words.
    `OFS_ASSERT_NEXT(a_one_classify, clk, rst_n, in_valid && in_ready && operation, !in_ready)

endmodule

bind os_fingerprint_scorer ofs_checker u_ofs_checker (.*);
